/* rtl/deq_pkg.sv */
// Shared types and constants for the double-ended queue unit.
// Depends on nothing; deq_if.sv, the top level and deq_ctrl use it, while deq_mem does not.
`timescale 1ns / 1ps

package deq_pkg;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_DEPTH      = 1024;
    localparam int DEFAULT_DATA_WIDTH = 32;

    // Fixed widths of the channel fields.
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 11;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_READ_FRONT = 3'd4,
        ACT_READ_BACK  = 3'd5
    } action_t;

    // Status of one item, produced by the pointer control and held with the result.
    typedef struct packed {
        logic               rd;
        logic               error;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } status_t;

endpackage

/* rtl/deq_if.sv */
// Handshake channels of the double-ended queue unit: command in, response out.
// Depends on deq_pkg for the field widths.
`timescale 1ns / 1ps

interface deq_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [deq_pkg::ACTION_W-1:0]        action;
    logic signed [deq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface deq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [deq_pkg::VALUE_W-1:0]  data;
    logic                                error;
    logic [deq_pkg::COUNT_W-1:0]         count;
    logic                                is_empty;

    modport source (output valid, output data, output error, output count,
                    output is_empty, input ready);
    modport sink   (input valid, input data, input error, input count,
                    input is_empty, output ready);
endinterface

/* rtl/double_ended_queue_unit.sv */
// Top level of the double-ended queue unit: pointer control, element store, result stage.
// Depends on deq_pkg, the channel interfaces in deq_if.sv, deq_ctrl and deq_mem.
`timescale 1ns / 1ps

// Channel  Direction  Fields                           Meaning
// cmd      in         action, value                    push, pop or read at either end
// rsp      out        data, error, count, is_empty     one result item per command item
//
// The unit takes one command item per cycle. Pointers and count live in registers and are
// updated at the edge that accepts an item; the store is read or written in that same cycle,
// and the result appears in the next cycle, its data straight from the store's read register.
// A result waits in the output stage until taken; a new command is accepted in the cycle the
// waiting result leaves, so a stalled response holds back commands for as long as it stalls.
// Reset empties the queue at once; store contents are not cleared and need no clearing pass.

module double_ended_queue_unit #(
    parameter int DEPTH      = deq_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEFAULT_DATA_WIDTH
) (
    input logic    clk,
    input logic    rst_n,
    deq_cmd_if.sink   cmd,
    deq_rsp_if.source rsp
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    // Working width that holds both a stored word and a channel word.
    localparam int EW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    logic                  accept;
    logic                  we;
    logic                  re;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [EW-1:0]         value_ext;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] rdata;
    logic signed [EW-1:0]  rdata_ext;
    status_t               status;
    status_t               status_reg;
    logic                  out_valid_reg, out_valid_next;

    // The output stage frees up in the same cycle its result is taken.
    assign cmd.ready = !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    // Only the low DATA_WIDTH bits of a pushed value are kept.
    assign value_ext = EW'($unsigned(cmd.value));
    assign wdata     = value_ext[DATA_WIDTH-1:0];

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .action (action_t'(cmd.action)),
        .we     (we),
        .waddr  (waddr),
        .re     (re),
        .raddr  (raddr),
        .status (status)
    );

    deq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status;
        end
    end

    // Stored words are sign-extended from DATA_WIDTH; pushes and errors return zero.
    assign rdata_ext = EW'(signed'(rdata));

    assign rsp.valid    = out_valid_reg;
    assign rsp.data     = status_reg.rd ? signed'(rdata_ext[VALUE_W-1:0]) : '0;
    assign rsp.error    = status_reg.error;
    assign rsp.count    = status_reg.count;
    assign rsp.is_empty = status_reg.is_empty;

endmodule

/* rtl/deq_mem.sv */
// Element store of the queue: one write port and one registered read port.
// Depends on nothing beyond the timescale.
`timescale 1ns / 1ps

module deq_mem #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]    rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data is only refreshed on a read, so it holds while the response stalls.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/deq_ctrl.sv */
// Front and rear pointers and the element count; decodes each item into store accesses.
// Depends on deq_pkg for the action codes and the status type.
`timescale 1ns / 1ps

module deq_ctrl #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  deq_pkg::action_t         action,
    output logic                     we,
    output logic [$clog2(DEPTH)-1:0] waddr,
    output logic                     re,
    output logic [$clog2(DEPTH)-1:0] raddr,
    output deq_pkg::status_t         status
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    logic          empty;
    logic          full;
    logic [AW-1:0] head_up, head_down, tail_up, tail_down;
    logic          error;
    logic          rd;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_COUNT);

    assign head_up   = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
    assign head_down = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
    assign tail_up   = (tail_reg == LAST_SLOT) ? '0 : tail_reg + AW'(1);
    assign tail_down = (tail_reg == '0) ? LAST_SLOT : tail_reg - AW'(1);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        we         = 1'b0;
        waddr      = head_down;
        re         = 1'b0;
        raddr      = head_reg;
        error      = 1'b0;
        rd         = 1'b0;
        unique case (action)
            ACT_PUSH_FRONT:
            begin
                if (full)
                begin
                    error = 1'b1;
                end
                else
                begin
                    we         = accept;
                    waddr      = head_down;
                    head_next  = head_down;
                    count_next = count_reg + CW'(1);
                    if (empty)
                    begin
                        tail_next = head_down;
                    end
                end
            end
            ACT_PUSH_BACK:
            begin
                if (full)
                begin
                    error = 1'b1;
                end
                else
                begin
                    we         = accept;
                    waddr      = tail_up;
                    tail_next  = tail_up;
                    count_next = count_reg + CW'(1);
                    if (empty)
                    begin
                        head_next = tail_up;
                    end
                end
            end
            ACT_POP_FRONT:
            begin
                if (empty)
                begin
                    error = 1'b1;
                end
                else
                begin
                    re         = accept;
                    rd         = 1'b1;
                    raddr      = head_reg;
                    head_next  = head_up;
                    count_next = count_reg - CW'(1);
                end
            end
            ACT_POP_BACK:
            begin
                if (empty)
                begin
                    error = 1'b1;
                end
                else
                begin
                    re         = accept;
                    rd         = 1'b1;
                    raddr      = tail_reg;
                    tail_next  = tail_down;
                    count_next = count_reg - CW'(1);
                end
            end
            ACT_READ_FRONT:
            begin
                if (empty)
                begin
                    error = 1'b1;
                end
                else
                begin
                    re    = accept;
                    rd    = 1'b1;
                    raddr = head_reg;
                end
            end
            ACT_READ_BACK:
            begin
                if (empty)
                begin
                    error = 1'b1;
                end
                else
                begin
                    re    = accept;
                    rd    = 1'b1;
                    raddr = tail_reg;
                end
            end
            default:
            begin
                error = 1'b1;
            end
        endcase

        // A queue that drains returns both pointers to their start slots.
        if (count_next == '0)
        begin
            head_next = '0;
            tail_next = LAST_SLOT;
        end
    end

    assign status.rd       = rd;
    assign status.error    = error;
    assign status.count    = COUNT_W'(count_next);
    assign status.is_empty = (count_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= LAST_SLOT;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule
